@@ rtl/bootloader_frame_receiver_unit_defines.svh @@
// Assertion macros shared by the checker.
`ifndef BOOTLOADER_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define BOOTLOADER_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define BFR_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define BFR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bfr_pkg.sv @@
`default_nettype none
package bfr_pkg;

	typedef enum logic [2:0] {
		KIND_SET_UART = 3'd0,
		KIND_FILL     = 3'd1,
		KIND_BOOT     = 3'd2,
		KIND_ERASE    = 3'd3,
		KIND_RESTART  = 3'd4
	} kind_t;

	localparam int unsigned REG_APP_PRESENT = 0;
	localparam int unsigned REG_CLOCK_HZ    = 1;
	localparam int unsigned CFG_IDX_W       = 1;

	localparam logic [7:0] BYTE_PREAMBLE = 8'haa;
	localparam logic [7:0] BYTE_COLON    = 8'h3a;
	localparam logic [7:0] BYTE_START    = 8'h53;
	localparam logic [2:0] PREAMBLE_MIN  = 3'd4;
	localparam logic [11:0] DIV_MAX      = 12'hfff;

	// Command from the parser to the page/divisor engine.
	typedef enum logic [1:0] {
		CMD_SINGLE = 2'd0,
		CMD_DIVIDE = 2'd1,
		CMD_PAGE   = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		kind_t       kind;
		logic        parity_on;
		logic [14:0] rate;
		logic [15:0] page_addr;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] baud_divisor;
		logic        parity_on;
		logic [15:0] flash_addr;
		logic [15:0] word_data;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/bfr_if.sv @@
`default_nettype none
interface bfr_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	modport source (output valid, op, rx_byte, input ready);
	modport sink (input valid, op, rx_byte, output ready);
endinterface

interface bfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [11:0] baud_divisor;
	logic        parity_on;
	logic [15:0] flash_addr;
	logic [15:0] word_data;
	logic        last;
	modport source (output valid, kind, baud_divisor, parity_on, flash_addr, word_data, last,
		input ready);
	modport sink (input valid, kind, baud_divisor, parity_on, flash_addr, word_data, last,
		output ready);
endinterface

interface bfr_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [26:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/bfr_parser.sv @@
`default_nettype none
module bfr_parser
	import bfr_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 256,
	localparam int unsigned BUF_AW = $clog2(BUFFER_BYTES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_op,
	input  wire logic [7:0]        in_byte,
	input  wire logic              app_present,
	input  wire logic              page_busy,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output cmd_t                   cmd,
	output logic                   wr_en,
	output logic [BUF_AW-1:0]      wr_addr,
	output logic [7:0]             wr_data
);

	typedef enum logic [3:0] {
		PH_PRE1, PH_CFG0, PH_CFG1, PH_PRE2, PH_COLON, PH_LEN, PH_ALO, PH_AHI, PH_CSUM,
		PH_DATA
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  pre_cnt_q;
	logic [7:0]  cfg_hold_q;
	logic [7:0]  len_q;
	logic [15:0] addr_q;
	logic [7:0]  sum_q;
	logic [7:0]  idx_q;
	logic        written_q;

	logic       acc;
	logic [7:0] sum_nx;
	logic [7:0] idx_nx;
	logic [14:0] rate;
	kind_t      boot_kind, fail_kind;

	// A command may be needed for any byte, so take a byte only with queue room.
	// Hold data bytes while an earlier page is still queued or being read out.
	assign in_ready = cmd_ready && !(phase_q == PH_DATA && page_busy);
	assign acc = in_valid && in_ready;
	assign sum_nx = sum_q + in_byte;
	assign idx_nx = idx_q + 8'd1;
	assign rate = {cfg_hold_q[6:0], in_byte};
	assign boot_kind = app_present ? KIND_BOOT : KIND_RESTART;
	assign fail_kind = (!written_q && app_present) ? KIND_BOOT : KIND_ERASE;

	assign wr_en = acc && !in_op && phase_q == PH_DATA
		&& {1'b0, idx_q} < 9'(BUFFER_BYTES);
	assign wr_addr = idx_q[BUF_AW-1:0];
	assign wr_data = in_byte;

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '0;
		cmd.op = CMD_SINGLE;
		cmd.kind = boot_kind;
		cmd.page_addr = addr_q;
		cmd.rate = rate;
		cmd.parity_on = cfg_hold_q[7];
		if (acc) begin
			case (phase_q)
				PH_CFG0: cmd_valid = in_op;
				PH_CFG1: begin
					cmd_valid = 1'b1;
					if (!in_op && rate != '0) cmd.op = CMD_DIVIDE;
				end
				PH_COLON: begin
					cmd_valid = in_op || in_byte != BYTE_COLON;
					cmd.kind = fail_kind;
				end
				PH_LEN: begin
					cmd_valid = in_op || in_byte == BYTE_START;
					cmd.kind = in_op ? fail_kind : KIND_BOOT;
				end
				PH_ALO, PH_AHI: begin
					cmd_valid = in_op;
					cmd.kind = fail_kind;
				end
				PH_CSUM: begin
					cmd.kind = fail_kind;
					cmd_valid = in_op || len_q == 8'd0;
					if (!in_op && sum_nx == 8'd0) cmd.op = CMD_PAGE;
				end
				PH_DATA: begin
					cmd.kind = fail_kind;
					cmd_valid = in_op || idx_nx == len_q;
					if (!in_op && sum_nx == 8'd0) cmd.op = CMD_PAGE;
				end
				default: begin
					cmd_valid = in_op || (in_byte != BYTE_PREAMBLE
						&& !(pre_cnt_q >= PREAMBLE_MIN && in_byte == BYTE_COLON));
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE1;
			pre_cnt_q <= '0;
			cfg_hold_q <= '0;
			len_q <= '0;
			addr_q <= '0;
			sum_q <= '0;
			idx_q <= '0;
			written_q <= 1'b0;
		end else if (acc) begin
			if (cmd_valid && cmd.op != CMD_PAGE && cmd.op != CMD_DIVIDE) begin
				// any single result restarts the receiver
				phase_q <= PH_PRE1;
				pre_cnt_q <= '0;
				cfg_hold_q <= '0;
				len_q <= '0;
				addr_q <= '0;
				sum_q <= '0;
				idx_q <= '0;
				written_q <= 1'b0;
			end else begin
				case (phase_q)
					PH_CFG0: begin
						cfg_hold_q <= in_byte;
						phase_q <= PH_CFG1;
					end
					PH_CFG1: begin
						phase_q <= PH_PRE2;
						pre_cnt_q <= '0;
					end
					PH_COLON: phase_q <= PH_LEN;
					PH_LEN: begin
						len_q <= in_byte;
						sum_q <= in_byte;
						phase_q <= PH_ALO;
					end
					PH_ALO: begin
						addr_q[7:0] <= in_byte;
						sum_q <= sum_nx;
						phase_q <= PH_AHI;
					end
					PH_AHI: begin
						addr_q[15:8] <= in_byte;
						sum_q <= sum_nx;
						phase_q <= PH_CSUM;
					end
					PH_CSUM: begin
						sum_q <= sum_nx;
						idx_q <= '0;
						if (len_q == 8'd0) begin
							written_q <= 1'b1;
							phase_q <= PH_COLON;
						end else begin
							phase_q <= PH_DATA;
						end
					end
					PH_DATA: begin
						sum_q <= sum_nx;
						idx_q <= idx_nx;
						if (idx_nx == len_q) begin
							written_q <= 1'b1;
							phase_q <= PH_COLON;
						end
					end
					default: begin
						if (in_byte == BYTE_PREAMBLE) begin
							if (phase_q != PH_PRE2) phase_q <= PH_PRE1;
							if (pre_cnt_q < PREAMBLE_MIN) pre_cnt_q <= pre_cnt_q + 3'd1;
						end else begin
							pre_cnt_q <= '0;
							phase_q <= (phase_q == PH_PRE2) ? PH_LEN : PH_CFG0;
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bfr_fifo.sv @@
`default_nettype none
module bfr_fifo
	import bfr_pkg::*;
#(
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire cmd_t wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output cmd_t      rd_data
);

	cmd_t        mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/bfr_engine.sv @@
`default_nettype none
module bfr_engine
	import bfr_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 256,
	parameter int unsigned PAGE_BYTES = 128,
	localparam int unsigned BUF_AW = $clog2(BUFFER_BYTES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire cmd_t              cmd,
	input  wire logic [26:0]       clock_hz,
	input  wire logic              wr_en,
	input  wire logic [BUF_AW-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	output logic                   busy,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output result_t                res
);

	localparam int unsigned WORDS = PAGE_BYTES / 2;
	localparam int unsigned WW = $clog2(WORDS + 1);
	localparam int unsigned NUM_W = 31;
	localparam int unsigned DEN_W = 19;

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_DIVFIN, ST_RD, ST_PAGE} st_t;

	// Buffer kept as byte pairs so one read gives a whole word.
	logic [7:0] mem_lo_q [BUFFER_BYTES/2];
	logic [7:0] mem_hi_q [BUFFER_BYTES/2];
	logic [BUFFER_BYTES/2-1:0] vld_lo_q;
	logic [BUFFER_BYTES/2-1:0] vld_hi_q;

	st_t          st_q;
	cmd_t         cur_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [4:0]   step_q;
	logic [WW-1:0] widx_q;
	logic [7:0]   rd_lo_s1, rd_hi_s1;
	logic         rd_lo_ok_s1, rd_hi_ok_s1;
	logic [WW-1:0] rd_w_s1;
	logic         out_v_q;
	result_t      out_q;
	logic         out_free;
	logic         out_load;
	result_t      out_nx;
	logic         page_last;
	logic         rd_in_buf;
	logic [BUF_AW-2:0] rd_row;
	logic [NUM_W:0] trial;
	logic [NUM_W-1:0] v_sum;
	logic [NUM_W-1:0] v_div;
	logic [11:0]  div_cl;

	assign out_free = !out_v_q || res_ready;
	assign res_valid = out_v_q;
	assign res = out_q;
	assign busy = st_q != ST_IDLE;
	assign cmd_ready = st_q == ST_IDLE && out_free;
	assign rd_row = (BUF_AW-1)'(widx_q);
	assign rd_in_buf = {1'b0, widx_q} < (WW+1)'(BUFFER_BYTES / 2);
	assign page_last = rd_w_s1 == WW'(WORDS - 1);
	assign trial = {rem_q, quo_q[NUM_W-1]} - {{(NUM_W-DEN_W+1){1'b0}}, den_q};
	// (q + 5) / 10 via reciprocal multiply on a 31-bit value
	assign v_sum = quo_q + NUM_W'(5);
	always_comb begin
		logic [63:0] prod;
		logic [NUM_W-1:0] q0;
		prod = 64'(v_sum) * 64'd3435973837;
		q0 = NUM_W'(prod >> 35);
		v_div = q0;
	end
	assign div_cl = (v_div == '0) ? 12'd0 :
		((v_div - NUM_W'(1)) > NUM_W'(DIV_MAX)) ? DIV_MAX : 12'(v_div - NUM_W'(1));

	always_comb begin
		out_load = 1'b0;
		out_nx = '0;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid && cmd_ready && cmd.op != CMD_DIVIDE && cmd.op != CMD_PAGE) begin
					out_load = 1'b1;
					out_nx.kind = cmd.kind;
				end
			end
			ST_DIV, ST_RD: out_load = 1'b0;
			ST_DIVFIN: begin
				out_load = out_free;
				out_nx.kind = KIND_SET_UART;
				out_nx.baud_divisor = div_cl;
				out_nx.parity_on = cur_q.parity_on;
			end
			default: begin
				out_load = out_free;
				out_nx.kind = KIND_FILL;
				out_nx.flash_addr = cur_q.page_addr + 16'({rd_w_s1, 1'b0});
				out_nx.word_data = {rd_hi_ok_s1 ? rd_hi_s1 : 8'd0, rd_lo_ok_s1 ? rd_lo_s1 : 8'd0};
				out_nx.last = page_last;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_addr[0]) mem_hi_q[wr_addr[BUF_AW-1:1]] <= wr_data;
			else mem_lo_q[wr_addr[BUF_AW-1:1]] <= wr_data;
		end
		rd_lo_s1 <= mem_lo_q[rd_row];
		rd_hi_s1 <= mem_hi_q[rd_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_lo_q <= '0;
			vld_hi_q <= '0;
		end else if (wr_en) begin
			if (wr_addr[0]) vld_hi_q[wr_addr[BUF_AW-1:1]] <= 1'b1;
			else vld_lo_q[wr_addr[BUF_AW-1:1]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_v_q <= 1'b0;
			out_q <= '0;
			cur_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			step_q <= '0;
			widx_q <= '0;
			rd_lo_ok_s1 <= 1'b0;
			rd_hi_ok_s1 <= 1'b0;
			rd_w_s1 <= '0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
				out_q <= out_nx;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cur_q <= cmd;
						case (cmd.op)
							CMD_DIVIDE: begin
								quo_q <= NUM_W'(clock_hz) * NUM_W'(10);
								den_q <= {cmd.rate, 4'd0};
								rem_q <= '0;
								step_q <= '0;
								st_q <= ST_DIV;
							end
							CMD_PAGE: begin
								widx_q <= '0;
								st_q <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (!trial[NUM_W]) rem_q <= trial[NUM_W-1:0];
					else rem_q <= {rem_q[NUM_W-2:0], quo_q[NUM_W-1]};
					quo_q <= {quo_q[NUM_W-2:0], !trial[NUM_W]};
					step_q <= step_q + 5'd1;
					if (step_q == 5'(NUM_W - 1)) st_q <= ST_DIVFIN;
				end
				ST_DIVFIN: begin
					if (out_free) st_q <= ST_IDLE;
				end
				ST_RD: begin
					rd_lo_ok_s1 <= vld_lo_q[rd_row] && rd_in_buf;
					rd_hi_ok_s1 <= vld_hi_q[rd_row] && rd_in_buf;
					rd_w_s1 <= widx_q;
					st_q <= ST_PAGE;
				end
				default: begin
					if (out_free) begin
						if (page_last) begin
							st_q <= ST_IDLE;
						end else begin
							widx_q <= rd_w_s1 + WW'(1);
							st_q <= ST_RD;
						end
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/bootloader_frame_receiver_unit.sv @@
// Single results pass through the command queue and the output register; the baud
// setting also waits for the restoring division. Page: each fill word takes a buffer
// read, then the output register, 64 words in all.
// Throughput: one byte per cycle while the command queue has room; data bytes
// hold while an earlier page is still queued or being read out.
// Reset (arst_n low) returns to preamble wait, restores default registers
// and marks every buffer byte as zero through per-byte valid bits.
`default_nettype none
module bootloader_frame_receiver_unit
	import bfr_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 256,
	parameter int unsigned PAGE_BYTES = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bfr_in_if.sink    in_ch,
	bfr_out_if.source out_ch,
	bfr_cfg_if.sink   cfg_ch
);

	localparam int unsigned BUF_AW = $clog2(BUFFER_BYTES);

	logic        app_q;
	logic [26:0] clk_hz_q;
	logic        pq_valid, pq_ready, eq_valid, eq_ready;
	cmd_t        pq_cmd, eq_cmd;
	logic        wr_en;
	logic [BUF_AW-1:0] wr_addr;
	logic [7:0]  wr_data;
	logic        eng_busy;
	logic        page_busy;
	result_t     res;

	assign page_busy = eq_valid || eng_busy;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_q <= 1'b0;
			clk_hz_q <= 27'd16000000;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == 1'(REG_APP_PRESENT)) app_q <= cfg_ch.data[0];
			else clk_hz_q <= cfg_ch.data;
		end
	end

	bfr_parser #(.BUFFER_BYTES(BUFFER_BYTES)) u_parser (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_op(in_ch.op), .in_byte(in_ch.rx_byte),
		.app_present(app_q),
		.page_busy(page_busy),
		.cmd_valid(pq_valid), .cmd_ready(pq_ready), .cmd(pq_cmd),
		.wr_en, .wr_addr, .wr_data
	);

	bfr_fifo #(.DEPTH(2)) u_fifo (
		.clk, .arst_n,
		.wr_valid(pq_valid), .wr_ready(pq_ready), .wr_data(pq_cmd),
		.rd_valid(eq_valid), .rd_ready(eq_ready), .rd_data(eq_cmd)
	);

	bfr_engine #(.BUFFER_BYTES(BUFFER_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_engine (
		.clk, .arst_n,
		.cmd_valid(eq_valid), .cmd_ready(eq_ready), .cmd(eq_cmd),
		.clock_hz(clk_hz_q),
		.wr_en, .wr_addr, .wr_data,
		.busy(eng_busy),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
	);

	assign out_ch.kind = res.kind;
	assign out_ch.baud_divisor = res.baud_divisor;
	assign out_ch.parity_on = res.parity_on;
	assign out_ch.flash_addr = res.flash_addr;
	assign out_ch.word_data = res.word_data;
	assign out_ch.last = res.last;

endmodule
`default_nettype wire

@@ rtl/bfr_checker.sv @@
`default_nettype none
`include "bootloader_frame_receiver_unit_defines.svh"
module bfr_checker
	import bfr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [15:0] word_data,
	input wire logic        last
);

	`BFR_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid, kind <= 3'(KIND_RESTART), "bad kind")
	`BFR_ASSERT_IMP(a_last_fill, clk, arst_n, out_valid && last, kind == 3'(KIND_FILL), "last")
	`BFR_ASSERT_IMP(a_word_zero, clk, arst_n, out_valid && kind != 3'(KIND_FILL), word_data == '0, "word")
	`BFR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind), "hold")

endmodule

bind bootloader_frame_receiver_unit bfr_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.kind(out_ch.kind), .word_data(out_ch.word_data), .last(out_ch.last)
);
`default_nettype wire

@@ sim/bfr_tb_if.sv @@
`default_nettype none
// Interfaces come from the RTL (rtl/bfr_if.sv); this file holds the item types
// that the driver and the state model share.
package bfr_tb_pkg;
	import bfr_pkg::*;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct {
		logic       is_cfg;
		logic       cfg_index;
		logic [26:0] cfg_data;
		rx_item_t   item;
	} pending_t;
endpackage
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bfr_pkg::*;
	import bfr_tb_pkg::*;

	localparam int BUF_BYTES = 256;
	localparam int PG_BYTES = 128;
	localparam int CYCLE_LIMIT = 5000000;

	typedef enum logic [3:0] {
		PH_PRE1, PH_CFG0, PH_CFG1, PH_PRE2, PH_COLON, PH_LEN, PH_ALO, PH_AHI, PH_CSUM,
		PH_DATA
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bfr_in_if in_ch();
	bfr_out_if out_ch();
	bfr_cfg_if cfg_ch();

	bootloader_frame_receiver_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// loader state mirror
	logic        m_app;
	logic [26:0] m_clock;
	phase_t      m_phase;
	logic [2:0]  m_pre_cnt;
	logic [7:0]  m_cfg_hold;
	logic [7:0]  m_len;
	logic [15:0] m_page;
	logic [7:0]  m_sum;
	logic [7:0]  m_idx;
	logic        m_written;
	logic [7:0]  m_buf [BUF_BYTES];

	result_t expected_q[$];
	pending_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	bit in_busy = 0;

	function automatic result_t mk(kind_t k);
		result_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic void go_idle();
		m_phase = PH_PRE1;
		m_pre_cnt = '0;
		m_cfg_hold = '0;
		m_len = '0;
		m_page = '0;
		m_sum = '0;
		m_idx = '0;
		m_written = 1'b0;
	endfunction

	function automatic void boot_or_restart();
		expected_q.push_back(mk(m_app ? KIND_BOOT : KIND_RESTART));
		go_idle();
	endfunction

	function automatic void frame_failed();
		expected_q.push_back(mk((!m_written && m_app) ? KIND_BOOT : KIND_ERASE));
		go_idle();
	endfunction

	function automatic void finish_frame();
		result_t r;
		if (m_sum != 0) begin
			frame_failed();
			return;
		end
		for (int i = 0; i < PG_BYTES; i += 2) begin
			r = mk(KIND_FILL);
			r.flash_addr = m_page + 16'(i);
			r.word_data = {m_buf[i + 1], m_buf[i]};
			r.last = (i + 2 >= PG_BYTES);
			expected_q.push_back(r);
		end
		m_written = 1'b1;
		m_phase = PH_COLON;
	endfunction

	function automatic logic [11:0] baud_divisor_for(logic [14:0] rate);
		longint unsigned q, v;
		q = (longint'(m_clock) * 10) / (16 * longint'(rate));
		v = (q + 5) / 10;
		if (v == 0) return 12'd0;
		v -= 1;
		return (v > 4095) ? DIV_MAX : 12'(v);
	endfunction

	function automatic void predict_byte(rx_item_t it);
		logic fail;
		logic [7:0] b;
		logic [14:0] rate;
		result_t r;
		fail = it.op;
		b = it.rx_byte;
		case (m_phase)
			PH_CFG0: begin
				if (fail) boot_or_restart();
				else begin
					m_cfg_hold = b;
					m_phase = PH_CFG1;
				end
			end
			PH_CFG1: begin
				rate = {m_cfg_hold[6:0], b};
				if (fail || rate == 0) boot_or_restart();
				else begin
					r = mk(KIND_SET_UART);
					r.baud_divisor = baud_divisor_for(rate);
					r.parity_on = m_cfg_hold[7];
					expected_q.push_back(r);
					m_phase = PH_PRE2;
					m_pre_cnt = '0;
				end
			end
			PH_COLON: begin
				if (fail || b != BYTE_COLON) frame_failed();
				else m_phase = PH_LEN;
			end
			PH_LEN: begin
				if (fail) frame_failed();
				else if (b == BYTE_START) begin
					expected_q.push_back(mk(KIND_BOOT));
					go_idle();
				end else begin
					m_len = b;
					m_sum = b;
					m_phase = PH_ALO;
				end
			end
			PH_ALO: begin
				if (fail) frame_failed();
				else begin
					m_page[7:0] = b;
					m_sum += b;
					m_phase = PH_AHI;
				end
			end
			PH_AHI: begin
				if (fail) frame_failed();
				else begin
					m_page[15:8] = b;
					m_sum += b;
					m_phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				if (fail) frame_failed();
				else begin
					m_sum += b;
					m_idx = '0;
					if (m_len == 0) finish_frame();
					else m_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				if (fail) frame_failed();
				else begin
					m_buf[m_idx] = b;
					m_sum += b;
					m_idx += 8'd1;
					if (m_idx == m_len) finish_frame();
				end
			end
			default: begin
				if (m_phase != PH_PRE2) m_phase = PH_PRE1;
				if (fail) boot_or_restart();
				else if (b == BYTE_PREAMBLE) begin
					if (m_pre_cnt < PREAMBLE_MIN) m_pre_cnt++;
				end else if (m_pre_cnt >= PREAMBLE_MIN && b == BYTE_COLON) begin
					m_pre_cnt = '0;
					m_phase = (m_phase == PH_PRE1) ? PH_CFG0 : PH_LEN;
				end else boot_or_restart();
			end
		endcase
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// driver
	int in_gap = 0;
	pending_t cur;
	bit in_acc = 1'b0;
	bit cfg_acc = 1'b0;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = 1'b0;
		in_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = 1'b0;
		cfg_ch.data = '0;
	end

	// Record transactions at the rising edge; the driver acts on them at the falling edge.
	always @(posedge clk) begin
		in_acc = arst_n && in_ch.valid && in_ch.ready;
		cfg_acc = arst_n && cfg_ch.valid && cfg_ch.ready;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				predict_byte('{op: in_ch.op, rx_byte: in_ch.rx_byte});
				in_busy = 0;
				in_gap = gap_len();
			end else if (cfg_acc) begin
				if (cfg_ch.index == REG_APP_PRESENT[0]) m_app = cfg_ch.data[0];
				else m_clock = cfg_ch.data;
				in_busy = 0;
			end
			if (!in_busy && pending_q.size() > 0) begin
				if (in_gap > 0) in_gap--;
				else if (pending_q[0].is_cfg && expected_q.size() > 0) begin
				end else begin
					cur = pending_q.pop_front();
					in_busy = 1;
					if (cur.is_cfg) begin
						cfg_ch.index <= cur.cfg_index;
						cfg_ch.data <= cur.cfg_data;
						cfg_ch.valid <= 1'b1;
						in_ch.valid <= 1'b0;
					end else begin
						in_ch.op <= cur.item.op;
						in_ch.rx_byte <= cur.item.rx_byte;
						in_ch.valid <= 1'b1;
						cfg_ch.valid <= 1'b0;
					end
				end
			end
			if (!in_busy) begin
				in_ch.valid <= 1'b0;
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor and output stall
	int out_gap = 0;
	initial out_ch.ready = 1'b0;
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			out_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	always @(posedge clk) begin
		result_t e;
		cycles++;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result kind=%0d", out_ch.kind);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_ch.kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, out_ch.kind); errors++;
				end
				if (out_ch.baud_divisor !== e.baud_divisor) begin
					$error("baud_divisor exp %0d got %0d", e.baud_divisor,
						out_ch.baud_divisor);
					errors++;
				end
				if (out_ch.parity_on !== e.parity_on) begin
					$error("parity_on exp %0d got %0d", e.parity_on, out_ch.parity_on);
					errors++;
				end
				if (out_ch.flash_addr !== e.flash_addr) begin
					$error("flash_addr exp %h got %h", e.flash_addr, out_ch.flash_addr);
					errors++;
				end
				if (out_ch.word_data !== e.word_data) begin
					$error("word_data exp %h got %h", e.word_data, out_ch.word_data);
					errors++;
				end
				if (out_ch.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_ch.last); errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// stimulus builders
	function automatic void push_byte(logic op, logic [7:0] b);
		pending_t p;
		p.is_cfg = 1'b0;
		p.cfg_index = 1'b0;
		p.cfg_data = '0;
		p.item.op = op;
		p.item.rx_byte = b;
		pending_q.push_back(p);
	endfunction

	function automatic void push_cfg(logic idx, logic [26:0] d);
		pending_t p;
		p.is_cfg = 1'b1;
		p.cfg_index = idx;
		p.cfg_data = d;
		p.item = '0;
		pending_q.push_back(p);
	endfunction

	function automatic void push_preamble(int n);
		for (int i = 0; i < n; i++) push_byte(1'b0, BYTE_PREAMBLE);
		push_byte(1'b0, BYTE_COLON);
	endfunction

	function automatic void push_frame(int len, bit good);
		logic [7:0] d [$];
		logic [7:0] s, lo, hi;
		lo = 8'($urandom);
		hi = 8'($urandom);
		s = 8'(len) + lo + hi;
		for (int i = 0; i < len; i++) begin
			d.push_back(8'($urandom));
			s += d[i];
		end
		push_byte(1'b0, BYTE_COLON);
		push_byte(1'b0, 8'(len));
		push_byte(1'b0, lo);
		push_byte(1'b0, hi);
		push_byte(1'b0, good ? 8'(-s) : 8'(-s) + 8'd1);
		foreach (d[i]) push_byte(1'b0, d[i]);
	endfunction

	function automatic void push_session(logic [7:0] c0, logic [7:0] c1);
		push_preamble($urandom_range(4, 6));
		push_byte(1'b0, c0);
		push_byte(1'b0, c1);
	endfunction

	task automatic wait_drain();
		while (pending_q.size() > 0 || in_busy || expected_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		int frames;
		m_app = 1'b0;
		m_clock = 27'd16000000;
		for (int i = 0; i < BUF_BYTES; i++) m_buf[i] = '0;
		go_idle();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: short sessions at default clock
		push_byte(1'b1, 8'hff);
		push_byte(1'b0, 8'h00);
		push_preamble(3);
		push_session(8'h80, 8'h00);
		push_session(8'h00, 8'h01);
		push_preamble(4);
		push_frame(0, 1);
		push_frame(2, 0);
		push_session(8'h7f, 8'hff);
		push_preamble(4);
		push_byte(1'b0, BYTE_COLON);
		push_byte(1'b0, BYTE_START);
		wait_drain();

		push_cfg(REG_APP_PRESENT[0], 27'd1);
		push_cfg(REG_CLOCK_HZ[0], 27'd100000000);
		push_session(8'h00, 8'h0a);
		push_byte(1'b1, 8'h00);
		push_session(8'h81, 8'h2c);
		push_preamble(4);
		push_frame(130, 1);
		push_byte(1'b0, 8'h00);
		wait_drain();

		// random sessions over several clock settings
		for (int ph = 0; ph < 4; ph++) begin
			push_cfg(REG_APP_PRESENT[0], 27'($urandom_range(0, 1)));
			push_cfg(REG_CLOCK_HZ[0], (ph == 0) ? 27'd1000000 : (ph == 1) ? 27'd100000000 :
				27'($urandom_range(1000000, 100000000)));
			push_session(8'($urandom), 8'($urandom));
			push_preamble($urandom_range(4, 5));
			frames = $urandom_range(1, 2);
			for (int f = 0; f < frames; f++)
				push_frame(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) :
					$urandom_range(0, 8), $urandom_range(0, 5) != 0);
			case ($urandom_range(0, 3))
				0: push_byte(1'b1, 8'($urandom));
				1: begin
					push_byte(1'b0, BYTE_COLON);
					push_byte(1'b0, BYTE_START);
				end
				2: push_byte(1'b0, 8'($urandom));
				default: for (int n = 0; n < 3; n++) push_byte(1'($urandom), 8'($urandom));
			endcase
			wait_drain();
		end
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

@@ bootloader_frame_receiver_unit.f @@
+incdir+rtl
rtl/bfr_pkg.sv
rtl/bfr_if.sv
rtl/bfr_parser.sv
rtl/bfr_fifo.sv
rtl/bfr_engine.sv
rtl/bootloader_frame_receiver_unit.sv
rtl/bfr_checker.sv
sim/bfr_tb_if.sv
sim/testbench.sv
